@@ hw/rtl/ssr_pkg.sv @@
// ----------------------------------------------------------------------------
// ssr_pkg: shared types and constants for the stepper speed ramp
// Field widths, opcodes, motion codes, register indexes and the
// controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package ssr_pkg;

  localparam int PERIOD_BITS = 32;
  localparam int COEF_BITS   = 48;
  localparam int CFG_BITS    = 48;
  localparam int CFG_IDX_BITS = 2;
  localparam int HALF_COEF   = COEF_BITS / 2;
  localparam int HALF_SQ     = PERIOD_BITS;
  localparam int SQ_BITS     = 2 * PERIOD_BITS;
  localparam int PP_BITS     = HALF_COEF + HALF_SQ;
  localparam int ACC_BITS    = COEF_BITS + SQ_BITS;
  localparam int DELTA_BITS  = 34;
  localparam int NEXT_BITS   = 35;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  localparam logic [1:0] MS_STOPPED  = 2'd0;
  localparam logic [1:0] MS_COASTING = 2'd1;
  localparam logic [1:0] MS_ACCEL    = 2'd2;
  localparam logic [1:0] MS_DECEL    = 2'd3;

  localparam logic [CFG_IDX_BITS-1:0] REG_START_PERIOD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_PERIOD   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ACC_COEF     = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEC_COEF     = 2'd3;

  localparam logic [PERIOD_BITS-1:0] START_PERIOD_RST = 32'd1000000;
  localparam logic [PERIOD_BITS-1:0] MIN_PERIOD_RST   = 32'd1000;
  localparam logic [COEF_BITS-1:0]   COEF_RST         = 48'd1;

  localparam logic [DELTA_BITS-1:0] DELTA_CAP = 34'h2_0000_0000;

  typedef struct packed {
    logic [1:0]             opcode;
    logic [PERIOD_BITS-1:0] target_period;
  } ssr_in_t;

  typedef struct packed {
    logic [PERIOD_BITS-1:0] period;
    logic                   period_valid;
    logic                   accepted;
    logic [1:0]             motion_code;
    logic                   event_fired;
  } ssr_out_t;

  typedef struct packed {
    logic       capture;
    logic       sq_en;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       acc_en;
    logic       delta_en;
    logic       commit;
  } ssr_cmd_t;

  typedef struct packed {
    logic run_step;
  } ssr_status_t;

endpackage

@@ hw/rtl/ssr_if.sv @@
// ----------------------------------------------------------------------------
// ssr_if: valid/ready channels of the stepper speed ramp
// Command channel and result channel, each with source and sink views.
// ----------------------------------------------------------------------------
interface ssr_in_if;
  logic              valid;
  logic              ready;
  ssr_pkg::ssr_in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ssr_out_if;
  logic              valid;
  logic              ready;
  ssr_pkg::ssr_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/ssr_datapath.sv @@
// ----------------------------------------------------------------------------
// ssr_datapath: ramp arithmetic and motion state
// Config registers, period state, squaring, a 24x32 multiply-accumulate for
// coef*cur^2, delta saturation and the step decision.
// ----------------------------------------------------------------------------
module ssr_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ssr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [ssr_pkg::CFG_BITS-1:0]        cfg_data,
  input  ssr_pkg::ssr_in_t                    in_data,
  input  ssr_pkg::ssr_cmd_t                   cmd,
  output ssr_pkg::ssr_status_t                status,
  output ssr_pkg::ssr_out_t                   out_data
);
  import ssr_pkg::*;

  logic [PERIOD_BITS-1:0] start_period;
  logic [PERIOD_BITS-1:0] min_period;
  logic [COEF_BITS-1:0]   acc_coef;
  logic [COEF_BITS-1:0]   dec_coef;

  logic [PERIOD_BITS-1:0] current_period;
  logic [PERIOD_BITS-1:0] target_hold;
  logic [1:0]             motion_state;

  logic [1:0]             op_q;
  logic [PERIOD_BITS-1:0] tgt_q;
  logic [SQ_BITS-1:0]     sq;
  logic [PP_BITS-1:0]     pp;
  logic [5:0]             pp_shift;
  logic [ACC_BITS-1:0]    acc;
  logic [DELTA_BITS-1:0]  delta;
  ssr_out_t               out_q;

  logic [COEF_BITS-1:0]   coef;
  logic [HALF_COEF-1:0]   mul_a;
  logic [HALF_SQ-1:0]     mul_b;
  logic [5:0]             shift_sel;
  logic [ACC_BITS-COEF_BITS-1:0] acc_hi;

  logic [PERIOD_BITS-1:0] cur_next;
  logic [1:0]             ms_next;
  ssr_out_t               res;

  assign status.run_step = (in_data.opcode == OP_STEP) && (motion_state != MS_STOPPED);
  assign out_data = out_q;

  assign coef  = (current_period > target_hold) ? acc_coef : dec_coef;
  assign mul_a = cmd.mul_sel[0] ? coef[COEF_BITS-1:HALF_COEF] : coef[HALF_COEF-1:0];
  assign mul_b = cmd.mul_sel[1] ? sq[SQ_BITS-1:HALF_SQ] : sq[HALF_SQ-1:0];

  always_comb begin
    unique case (cmd.mul_sel)
      2'd0:    shift_sel = 6'd0;
      2'd1:    shift_sel = 6'(HALF_COEF);
      2'd2:    shift_sel = 6'(HALF_SQ);
      default: shift_sel = 6'(HALF_COEF + HALF_SQ);
    endcase
  end

  assign acc_hi = acc[ACC_BITS-1:COEF_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      start_period <= START_PERIOD_RST;
      min_period   <= MIN_PERIOD_RST;
      acc_coef     <= COEF_RST;
      dec_coef     <= COEF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_PERIOD: start_period <= cfg_data[PERIOD_BITS-1:0];
        REG_MIN_PERIOD:   min_period   <= cfg_data[PERIOD_BITS-1:0];
        REG_ACC_COEF:     acc_coef     <= cfg_data[COEF_BITS-1:0];
        default:          dec_coef     <= cfg_data[COEF_BITS-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= in_data.opcode;
      tgt_q <= in_data.target_period;
    end
    if (cmd.sq_en) begin
      sq       <= SQ_BITS'(current_period) * SQ_BITS'(current_period);
      pp       <= '0;
      pp_shift <= '0;
    end else if (cmd.mul_en) begin
      pp       <= PP_BITS'(mul_a) * PP_BITS'(mul_b);
      pp_shift <= shift_sel;
    end
    if (cmd.sq_en) begin
      acc <= '0;
    end else if (cmd.acc_en) begin
      acc <= acc + (ACC_BITS'(pp) << pp_shift);
    end
    if (cmd.delta_en) begin
      if (acc_hi > ACC_BITS'(DELTA_CAP)) begin
        delta <= DELTA_CAP;
      end else begin
        delta <= acc_hi[DELTA_BITS-1:0];
      end
    end
    if (cmd.commit) begin
      out_q <= res;
    end
  end

  // step decision
  always_comb begin
    logic                 gt;
    logic                 lt;
    logic                 under;
    logic                 stop;
    logic [NEXT_BITS-1:0] cur_w;
    logic [NEXT_BITS-1:0] nxt;
    gt    = current_period > target_hold;
    lt    = current_period < target_hold;
    cur_w = NEXT_BITS'(current_period);
    nxt   = cur_w;
    under = 1'b0;
    stop  = 1'b0;
    cur_next = current_period;
    ms_next  = motion_state;
    res      = '0;

    unique case (op_q)
      OP_START: begin
        if (motion_state == MS_STOPPED) begin
          cur_next         = start_period;
          ms_next          = MS_ACCEL;
          res.period       = start_period;
          res.period_valid = 1'b1;
        end
      end
      OP_STOP: begin
        ms_next         = MS_STOPPED;
        res.event_fired = 1'b1;
      end
      OP_STEP: begin
        if (motion_state != MS_STOPPED) begin
          if (gt) begin
            if (NEXT_BITS'(delta) >= cur_w) begin
              under = 1'b1;
            end else begin
              nxt = cur_w - NEXT_BITS'(delta);
            end
          end else if (lt) begin
            nxt = cur_w + NEXT_BITS'(delta);
          end

          priority if (!under && nxt >= NEXT_BITS'(start_period)) begin
            stop = 1'b1;
          end else if (under || nxt < NEXT_BITS'(min_period)) begin
            nxt = NEXT_BITS'(min_period);
          end else if (nxt == cur_w) begin
            if (motion_state != MS_COASTING) begin
              ms_next         = MS_COASTING;
              res.event_fired = 1'b1;
            end
          end else if (nxt < cur_w) begin
            if (motion_state != MS_ACCEL) begin
              ms_next         = MS_ACCEL;
              res.event_fired = 1'b1;
            end
          end else begin
            if (motion_state != MS_DECEL) begin
              ms_next         = MS_DECEL;
              res.event_fired = 1'b1;
            end else if (nxt >= NEXT_BITS'(target_hold)) begin
              stop = 1'b1;
            end
          end

          if (stop) begin
            ms_next         = MS_STOPPED;
            res.event_fired = 1'b1;
          end else begin
            cur_next         = nxt[PERIOD_BITS-1:0];
            res.period       = nxt[PERIOD_BITS-1:0];
            res.period_valid = 1'b1;
            res.accepted     = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.motion_code = ms_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_period <= '0;
      target_hold    <= '0;
      motion_state   <= MS_STOPPED;
    end else if (cmd.commit) begin
      current_period <= cur_next;
      motion_state   <= ms_next;
      if (op_q == OP_START) begin
        target_hold <= tgt_q;
      end
    end
  end

endmodule

@@ hw/rtl/ssr_ctrl.sv @@
// ----------------------------------------------------------------------------
// ssr_ctrl: sequencer of the stepper speed ramp
// Accepts a beat, walks the square / multiply-accumulate / saturate steps
// for a running step command, commits and holds the result beat.
// ----------------------------------------------------------------------------
module ssr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  ssr_pkg::ssr_status_t status,
  output ssr_pkg::ssr_cmd_t    cmd
);
  import ssr_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SQ     = 4'd1;
  localparam logic [3:0] S_MUL0   = 4'd2;
  localparam logic [3:0] S_MUL1   = 4'd3;
  localparam logic [3:0] S_MUL2   = 4'd4;
  localparam logic [3:0] S_MUL3   = 4'd5;
  localparam logic [3:0] S_ACC    = 4'd6;
  localparam logic [3:0] S_DELTA  = 4'd7;
  localparam logic [3:0] S_COMMIT = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       accept;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.capture = accept;
        if (accept) begin
          state_next = status.run_step ? S_SQ : S_COMMIT;
        end
      end
      S_SQ: begin
        cmd.sq_en  = 1'b1;
        state_next = S_MUL0;
      end
      S_MUL0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = 2'd0;
        cmd.acc_en  = 1'b1;
        state_next  = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = 2'd1;
        cmd.acc_en  = 1'b1;
        state_next  = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = 2'd2;
        cmd.acc_en  = 1'b1;
        state_next  = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = 2'd3;
        cmd.acc_en  = 1'b1;
        state_next  = S_ACC;
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        state_next = S_DELTA;
      end
      S_DELTA: begin
        cmd.delta_en = 1'b1;
        state_next   = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/stepper_speed_ramp.sv @@
// ----------------------------------------------------------------------------
// stepper_speed_ramp: linear speed ramp for a stepper step generator
// Sequence: start, force stop and idle step beats go straight to the commit;
//   a running step beat first walks square, four 24x32 MACs, sum and saturate.
// A new beat is taken only in idle, with the result slot free or being taken.
// Reset: config registers return to their defaults, period state and target
//   clear, the motor is stopped; no beat is pending.
// ----------------------------------------------------------------------------
module stepper_speed_ramp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ssr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [ssr_pkg::CFG_BITS-1:0]      cfg_data,
  ssr_in_if.sink                            req,
  ssr_out_if.source                         rsp
);
  import ssr_pkg::*;

  ssr_cmd_t    cmd;
  ssr_status_t status;

  ssr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  ssr_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (req.data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (rsp.data)
  );

endmodule

@@ tb/tb_stepper_speed_ramp.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stepper_speed_ramp: self-checking bench for the stepper speed ramp
// Sends start, step and stop beats in random bursts and works out each result
// beat from its own copy of the ramp arithmetic and motion state. Every
// result is compared field by field while the result side stalls at random.
// ----------------------------------------------------------------------------
module tb_stepper_speed_ramp;
  import ssr_pkg::*;

  localparam logic [1:0] OP_UNDEF = 2'd3;
  localparam int CYCLE_LIMIT = 600000;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]     cfg_data;

  ssr_in_if  req_ch ();
  ssr_out_if rsp_ch ();

  stepper_speed_ramp DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  logic [PERIOD_BITS-1:0] start_p, min_p, cur_p, target_p;
  logic [COEF_BITS-1:0]   acc_c, dec_c;
  logic [1:0]             motion;
  ssr_out_t               pending[$];

  int errors = 0;
  int cycles = 0;
  int sent_cmds = 0;
  int burst_left = 0;
  int hold_req = 0;
  int hold_cnt = 0;
  bit gaps_on = 1'b1;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [DELTA_BITS-1:0] speed_delta(input logic [COEF_BITS-1:0] coef,
                                                       input logic [PERIOD_BITS-1:0] p);
    logic [SQ_BITS-1:0]  sq;
    logic [ACC_BITS-1:0] prod;
    sq   = SQ_BITS'(p) * SQ_BITS'(p);
    prod = ACC_BITS'(coef) * ACC_BITS'(sq);
    if (prod[ACC_BITS-1:COEF_BITS] > SQ_BITS'(DELTA_CAP))
      return DELTA_CAP;
    return prod[COEF_BITS+DELTA_BITS-1:COEF_BITS];
  endfunction

  task automatic advance_ramp(input ssr_in_t b);
    ssr_out_t              o;
    logic [NEXT_BITS-1:0]  nxt;
    logic [DELTA_BITS-1:0] d;
    logic                  under;
    logic                  halt;
    o     = '0;
    under = 1'b0;
    halt  = 1'b0;
    sent_cmds++;
    case (b.opcode)
      OP_START: begin
        target_p = b.target_period;
        if (motion == MS_STOPPED) begin
          cur_p          = start_p;
          o.period       = cur_p;
          o.period_valid = 1'b1;
          motion         = MS_ACCEL;
        end
      end
      OP_STOP: begin
        motion        = MS_STOPPED;
        o.event_fired = 1'b1;
      end
      OP_STEP: begin
        if (motion != MS_STOPPED) begin
          nxt = NEXT_BITS'(cur_p);
          if (cur_p > target_p) begin
            d = speed_delta(acc_c, cur_p);
            if (d >= DELTA_BITS'(cur_p))
              under = 1'b1;
            else
              nxt = NEXT_BITS'(cur_p) - NEXT_BITS'(d);
          end else if (cur_p < target_p) begin
            nxt = NEXT_BITS'(cur_p) + NEXT_BITS'(speed_delta(dec_c, cur_p));
          end

          if (!under && nxt >= NEXT_BITS'(start_p)) begin
            halt = 1'b1;
          end else if (under || nxt < NEXT_BITS'(min_p)) begin
            nxt = NEXT_BITS'(min_p);
          end else if (nxt == NEXT_BITS'(cur_p)) begin
            if (motion != MS_COASTING) begin
              motion        = MS_COASTING;
              o.event_fired = 1'b1;
            end
          end else if (nxt < NEXT_BITS'(cur_p)) begin
            if (motion != MS_ACCEL) begin
              motion        = MS_ACCEL;
              o.event_fired = 1'b1;
            end
          end else if (motion != MS_DECEL) begin
            motion        = MS_DECEL;
            o.event_fired = 1'b1;
          end else if (nxt >= NEXT_BITS'(target_p)) begin
            halt = 1'b1;
          end

          if (halt) begin
            motion        = MS_STOPPED;
            o.event_fired = 1'b1;
          end else begin
            cur_p          = nxt[PERIOD_BITS-1:0];
            o.period       = cur_p;
            o.period_valid = 1'b1;
            o.accepted     = 1'b1;
          end
        end
      end
      default: ;
    endcase
    o.motion_code = motion;
    pending.push_back(o);
  endtask

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    ssr_out_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing outstanding, period %0h",
                 $time, rsp_ch.data.period);
      end else begin
        want = pending.pop_front();
        check_field("period", want.period, rsp_ch.data.period);
        check_field("period_valid", 32'(want.period_valid), 32'(rsp_ch.data.period_valid));
        check_field("accepted", 32'(want.accepted), 32'(rsp_ch.data.accepted));
        check_field("motion_code", 32'(want.motion_code), 32'(rsp_ch.data.motion_code));
        check_field("event_fired", 32'(want.event_fired), 32'(rsp_ch.data.event_fired));
      end
    end
  end

  // result side: stall pattern of its own plus requested long hold-offs
  initial begin : rsp_stall
    int mode;
    int mode_left;
    mode         = 0;
    mode_left    = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_cnt = hold_req;
        hold_req = 0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 300);
      end else begin
        mode_left--;
      end
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt--;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
          2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_ch.ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  task automatic send_cmd(input logic [1:0] op, input logic [PERIOD_BITS-1:0] tgt);
    ssr_in_t b;
    b.opcode        = op;
    b.target_period = tgt;
    req_ch.valid <= 1'b1;
    req_ch.data  <= b;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    advance_ramp(b);
    @(negedge clk);
    if (gaps_on) begin
      if (burst_left <= 0) begin
        req_ch.valid <= 1'b0;
        repeat (($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4))
          @(negedge clk);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                                 : $urandom_range(1, 20);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    while (pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_config(input logic [PERIOD_BITS-1:0] sp, input logic [PERIOD_BITS-1:0] mp,
                             input logic [COEF_BITS-1:0] ac, input logic [COEF_BITS-1:0] dc);
    start_p = sp;
    min_p   = mp;
    acc_c   = ac;
    dec_c   = dc;
    cfg_we    <= 1'b1;
    cfg_index <= REG_START_PERIOD;
    cfg_data  <= CFG_BITS'(sp);
    @(negedge clk);
    cfg_index <= REG_MIN_PERIOD;
    cfg_data  <= CFG_BITS'(mp);
    @(negedge clk);
    cfg_index <= REG_ACC_COEF;
    cfg_data  <= CFG_BITS'(ac);
    @(negedge clk);
    cfg_index <= REG_DEC_COEF;
    cfg_data  <= CFG_BITS'(dc);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [PERIOD_BITS-1:0] pick_target();
    longint unsigned lo;
    longint unsigned hi;
    logic [31:0]     t;
    lo = longint'(min_p) / 2 + 1;
    hi = longint'(start_p) + longint'(start_p) / 4;
    if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
    if (lo >= hi || $urandom_range(0, 4) == 0) begin
      t = $urandom();
      return (t == 0) ? 32'd1 : t;
    end
    return $urandom_range(32'(hi), 32'(lo));
  endfunction

  // delta at start_period is 1/1024 .. 400/1024 of the period, with odd cases
  function automatic logic [COEF_BITS-1:0] ramp_coef(input logic [PERIOD_BITS-1:0] sp);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return COEF_BITS'({$urandom(), $urandom()});
      default: return COEF_BITS'((64'($urandom_range(1, 400)) << 38) / 64'(sp));
    endcase
  endfunction

  task automatic run_ramp();
    send_cmd(OP_START, pick_target());
    repeat ($urandom_range(2, 40)) send_cmd(OP_STEP, $urandom());
    if ($urandom_range(0, 3) == 0) begin
      send_cmd(OP_START, pick_target());
      repeat ($urandom_range(2, 30)) send_cmd(OP_STEP, $urandom());
    end
    if ($urandom_range(0, 5) == 0)
      send_cmd(OP_STOP, $urandom());
  endtask

  task automatic test_idle_commands();
    send_cmd(OP_STEP, 32'd0);
    send_cmd(OP_UNDEF, 32'hFFFF_FFFF);
    send_cmd(OP_STOP, 32'h5555_5555);
    send_cmd(OP_START, 32'd1);
    send_cmd(OP_STEP, 32'hAAAA_AAAA);
    send_cmd(OP_START, 32'hFFFF_FFFF);
    send_cmd(OP_STEP, 32'd0);
    send_cmd(OP_UNDEF, 32'd0);
    send_cmd(OP_STOP, 32'd0);
  endtask

  task automatic test_saturation();
    settle();
    load_config(32'hFFFF_FFFF, 32'd1, {COEF_BITS{1'b1}}, {COEF_BITS{1'b1}});
    send_cmd(OP_START, 32'd1);
    send_cmd(OP_STEP, 32'd0);
    send_cmd(OP_STEP, 32'd0);
    settle();
    // clamp floor above the start period
    load_config(32'd1000, 32'hFFFF_FFFF, '0, '0);
    send_cmd(OP_STOP, 32'd0);
    send_cmd(OP_START, 32'd500);
    send_cmd(OP_STEP, 32'd0);
    send_cmd(OP_STEP, 32'd0);
  endtask

  task automatic test_ramp_cycle();
    settle();
    load_config(32'd1000, 32'd10, COEF_BITS'(64'd1 << 35), COEF_BITS'(64'd1 << 35));
    send_cmd(OP_STOP, 32'd0);
    send_cmd(OP_START, 32'd200);
    repeat (3) send_cmd(OP_STEP, 32'd0);
    send_cmd(OP_START, 32'd900);
    repeat (3) send_cmd(OP_STEP, 32'd0);
    send_cmd(OP_START, 32'd5000);
    send_cmd(OP_STEP, 32'd0);
  endtask

  task automatic test_backpressure();
    int sent_goal;
    settle();
    load_config(32'd20000, 32'd50, ramp_coef(32'd20000), ramp_coef(32'd20000));
    hold_req  = 300;
    gaps_on   = 1'b0;
    sent_goal = sent_cmds + 40;
    while (sent_cmds < sent_goal) run_ramp();
    gaps_on = 1'b1;
    settle();
  endtask

  task automatic test_random_ramps();
    int                     goal;
    int                     phase_end;
    logic [PERIOD_BITS-1:0] sp;
    logic [PERIOD_BITS-1:0] mp;
    goal = sent_cmds + 750;
    while (sent_cmds < goal) begin
      settle();
      case ($urandom_range(0, 5))
        4: begin
          sp = $urandom_range(32'hFFFF_FFFF, 32'h8000_0000);
          mp = $urandom_range(1000, 1);
        end
        5: begin
          sp = $urandom_range(300000, 2);
          mp = $urandom_range(32'hFFFF_FFFF, sp);
        end
        default: begin
          sp = $urandom_range(300000, 50);
          mp = $urandom_range(sp / 3 + 1, 1);
        end
      endcase
      load_config(sp, mp, ramp_coef(sp), ramp_coef(sp));
      phase_end = sent_cmds + 110;
      while (sent_cmds < phase_end && sent_cmds < goal) begin
        if ($urandom_range(0, 9) == 0)
          send_cmd(2'($urandom_range(0, 3)), pick_target());
        else
          run_ramp();
      end
    end
    settle();
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    start_p      = START_PERIOD_RST;
    min_p        = MIN_PERIOD_RST;
    acc_c        = COEF_RST;
    dec_c        = COEF_RST;
    cur_p        = '0;
    target_p     = '0;
    motion       = MS_STOPPED;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_idle_commands();
    test_saturation();
    test_ramp_cycle();
    test_backpressure();
    test_random_ramps();

    settle();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/ssr_pkg.sv
hw/rtl/ssr_if.sv
hw/rtl/ssr_datapath.sv
hw/rtl/ssr_ctrl.sv
hw/rtl/stepper_speed_ramp.sv
tb/tb_stepper_speed_ramp.sv
